### rtl/core/u8d_pkg.sv
// shared types, constants and a helper function of the utf-8 stream decoder
package u8d_pkg;

    localparam int BYTE_W       = 8;
    localparam int CP_W         = 32;
    localparam int CNT_W        = 4;
    localparam int REM_W        = 3;
    localparam int PAYLOAD_BITS = 6;
    localparam int TOP_BIT      = 7;

    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(BYTE_W);

    typedef struct packed {
        logic [BYTE_W-1:0] byte_value;
        logic              end_of_buffer;
    } t_in_item;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [CNT_W-1:0] byte_count;
    } t_result;

    // handshake between the decode stage and the result register
    typedef struct packed {
        logic step;
        logic emit;
    } t_step_ctrl;

    // count of leading one bits of a byte, 0 to 8
    function automatic logic [CNT_W-1:0] lead_ones(input logic [BYTE_W-1:0] b);
        logic [CNT_W-1:0] n;
        logic             run;
        n   = '0;
        run = 1'b1;
        for (int i = TOP_BIT; i >= 0; i--) begin
            if (run && b[i]) begin
                n = n + CNT_ONE;
            end else begin
                run = 1'b0;
            end
        end
        return n;
    endfunction

endpackage

### rtl/core/u8d_in_if.sv
// byte request channel: valid, ready and one raw byte with its end flag
interface u8d_in_if;
    logic                      valid;
    logic                      ready;
    logic [u8d_pkg::BYTE_W-1:0] byte_value;
    logic                      end_of_buffer;

    modport source (output valid, output byte_value, output end_of_buffer, input ready);
    modport sink   (input valid, input byte_value, input end_of_buffer, output ready);
endinterface

### rtl/core/u8d_out_if.sv
// code point request channel: valid, ready and one decoded character
interface u8d_out_if;
    logic                       valid;
    logic                       ready;
    logic [u8d_pkg::CP_W-1:0]   code_point;
    logic [u8d_pkg::CNT_W-1:0]  byte_count;

    modport source (output valid, output code_point, output byte_count, input ready);
    modport sink   (input valid, input code_point, input byte_count, output ready);
endinterface

### rtl/core/u8d_in_reg.sv
// input register stage holding one byte request
module u8d_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    u8d_in_if.sink            i_in,
    input  logic              i_step,
    output logic              o_valid,
    output u8d_pkg::t_in_item o_item
);
    import u8d_pkg::*;

    logic     r_valid;
    t_in_item r_item;
    logic     accept;

    // the stage frees up in the same cycle its request moves on
    assign i_in.ready = !r_valid || i_step;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_step) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.byte_value    <= i_in.byte_value;
            r_item.end_of_buffer <= i_in.end_of_buffer;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### rtl/core/u8d_decode.sv
// sequence state and per-byte decode logic
module u8d_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  u8d_pkg::t_in_item i_item,
    output logic              o_emit,
    output u8d_pkg::t_result  o_result
);
    import u8d_pkg::*;

    logic [REM_W-1:0] r_rem, n_rem;
    logic [CP_W-1:0]  r_acc, n_acc;
    logic [CNT_W-1:0] r_len, n_len;

    logic [CNT_W-1:0]  ones;
    logic [BYTE_W-1:0] lead_payload;
    logic [CP_W-1:0]   shifted;
    logic [REM_W-1:0]  rem_dec;

    assign ones         = lead_ones(i_item.byte_value);
    assign lead_payload = i_item.byte_value & (8'hff >> ones);
    assign shifted      = {r_acc[CP_W-PAYLOAD_BITS-1:0],
                           i_item.byte_value[PAYLOAD_BITS-1:0]};
    assign rem_dec      = r_rem - REM_W'(1);

    always_comb begin
        n_rem    = r_rem;
        n_acc    = r_acc;
        n_len    = r_len;
        o_emit   = 1'b0;
        o_result = '{code_point: '0, byte_count: CNT_ONE};
        if (r_rem == '0) begin
            if (ones <= CNT_ONE) begin
                // ascii or lone continuation byte
                o_emit              = 1'b1;
                o_result.code_point = {{(CP_W-BYTE_W){1'b0}}, lead_payload};
                o_result.byte_count = CNT_ONE;
            end else if (!i_item.end_of_buffer) begin
                n_acc = {{(CP_W-BYTE_W){1'b0}}, lead_payload};
                n_len = ones;
                n_rem = REM_W'(ones - CNT_ONE);
            end
        end else begin
            n_acc = shifted;
            n_rem = rem_dec;
            if (rem_dec == '0) begin
                o_emit              = 1'b1;
                o_result.code_point = shifted;
                o_result.byte_count = r_len;
                n_acc               = '0;
                n_len               = '0;
            end else if (i_item.end_of_buffer) begin
                // cut off by the end of the buffer
                n_rem = '0;
                n_acc = '0;
                n_len = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
            r_acc <= '0;
            r_len <= '0;
        end else if (i_step) begin
            r_rem <= n_rem;
            r_acc <= n_acc;
            r_len <= n_len;
        end
    end

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rem == '0) |-> (r_len == '0 && r_acc == '0))
        else $error("idle decoder holds stale sequence state");

    a_len_above_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rem != '0) |-> (r_len > CNT_W'(r_rem) && r_len <= CNT_MAX))
        else $error("sequence length inconsistent with bytes remaining");

    a_emit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |-> (o_result.byte_count != '0 && o_result.byte_count <= CNT_MAX))
        else $error("emitted byte count out of range");

endmodule

### rtl/core/u8d_out_reg.sv
// result register driving the code point channel
module u8d_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  u8d_pkg::t_step_ctrl i_ctrl,
    input  u8d_pkg::t_result    i_result,
    output logic                o_free,
    u8d_out_if.source           o_out
);
    import u8d_pkg::*;

    logic    r_valid;
    t_result r_result;
    logic    load;

    assign load   = i_ctrl.step && i_ctrl.emit;
    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.code_point = r_result.code_point;
    assign o_out.byte_count = r_result.byte_count;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> o_free)
        else $error("result register loaded while a result still waits");

endmodule

### rtl/core/utf8_stream_decoder.sv
// top level of the lax utf-8 stream decoder
// path: each accepted byte is held in the input register, and a completed result in the result register
// throughput: one byte per cycle; a stall stops the input only once both
//   the input register and the result register are full
// reset: synchronous active low, clears sequence state and both valid flags
module utf8_stream_decoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    u8d_in_if.sink    i_in,
    u8d_out_if.source o_out
);
    import u8d_pkg::*;

    logic       in_valid;
    t_in_item   in_item;
    logic       out_free;
    t_step_ctrl ctrl;
    logic       emit;
    t_result    result;

    assign ctrl.step = in_valid && out_free;
    assign ctrl.emit = emit;

    u8d_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_step  (ctrl.step),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    u8d_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (ctrl.step),
        .i_item   (in_item),
        .o_emit   (emit),
        .o_result (result)
    );

    u8d_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .i_result (result),
        .o_free   (out_free),
        .o_out    (o_out)
    );

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_valid && o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while both stages are stalled");

endmodule

### verif/tb_utf8_stream_decoder.sv
// self-checking testbench of the lax utf-8 stream decoder
`timescale 1ns / 1ps

module tb_utf8_stream_decoder;
    import u8d_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int RESET_LEN   = 8;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_TAIL  = 6;
    localparam int MAX_REPORTS = 10;

    logic i_clk;
    logic i_rst_n;

    u8d_in_if  in_bus ();
    u8d_out_if out_bus ();

    utf8_stream_decoder uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // predicted decoder state
    logic [REM_W-1:0] dec_remaining;
    logic [CP_W-1:0]  dec_accum;
    logic [CNT_W-1:0] dec_length;

    t_result pending_chars[$];

    int mismatches;
    int cycle_count;
    int src_idle_pct;
    int sink_stall_pct;
    int hold_req;
    int hold_left;

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // decodes one accepted byte, returns 1 when a character completes
    function automatic logic decode_byte(input t_in_item item, output t_result ch);
        logic [CNT_W-1:0]  ones;
        logic [BYTE_W-1:0] b;
        logic              run;
        b    = item.byte_value;
        ones = '0;
        run  = 1'b1;
        ch   = '0;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            if (run && b[i]) begin
                ones = ones + 1'b1;
            end else begin
                run = 1'b0;
            end
        end
        if (dec_remaining == '0) begin
            if (ones <= 1) begin
                // plain ascii, or a lone continuation keeping its low six bits
                ch.code_point = (ones == 0) ? CP_W'(b) : CP_W'(b[5:0]);
                ch.byte_count = CNT_W'(1);
                return 1'b1;
            end
            if (item.end_of_buffer) begin
                return 1'b0;
            end
            dec_accum     = (ones >= CNT_W'(BYTE_W)) ? '0 : CP_W'(b & (8'hff >> ones));
            dec_length    = ones;
            dec_remaining = REM_W'(ones - 1'b1);
            return 1'b0;
        end
        dec_accum     = (dec_accum << PAYLOAD_BITS) + CP_W'(b[5:0]);
        dec_remaining = dec_remaining - 1'b1;
        if (dec_remaining == '0) begin
            ch.code_point = dec_accum;
            ch.byte_count = dec_length;
            dec_accum     = '0;
            dec_length    = '0;
            return 1'b1;
        end
        if (item.end_of_buffer) begin
            dec_remaining = '0;
            dec_accum     = '0;
            dec_length    = '0;
        end
        return 1'b0;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("mismatch %0s: expected 0x%0h, got 0x%0h at cycle %0d",
                     what, exp_v, act_v, cycle_count);
        end
    endtask

    // predicts on each accepted byte and checks each accepted character
    always @(posedge i_clk) begin
        t_in_item item;
        t_result  ch;
        t_result  want;
        if (i_rst_n) begin
            if (in_bus.valid && in_bus.ready) begin
                item.byte_value    = in_bus.byte_value;
                item.end_of_buffer = in_bus.end_of_buffer;
                if (decode_byte(item, ch)) begin
                    pending_chars.push_back(ch);
                end
            end
            if (out_bus.valid && out_bus.ready) begin
                if (pending_chars.size() == 0) begin
                    note_mismatch("unexpected character", 32'h0, out_bus.code_point);
                end else begin
                    want = pending_chars.pop_front();
                    if (out_bus.code_point !== want.code_point) begin
                        note_mismatch("code_point", want.code_point, out_bus.code_point);
                    end
                    if (out_bus.byte_count !== want.byte_count) begin
                        note_mismatch("byte_count", 32'(want.byte_count),
                                      32'(out_bus.byte_count));
                    end
                end
            end
        end
    end

    // receiver: random stalls plus an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eob);
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
            @(negedge i_clk);
            in_bus.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_bus.valid         <= 1'b1;
        in_bus.byte_value    <= b;
        in_bus.end_of_buffer <= eob;
        @(posedge i_clk);
        while (!(in_bus.valid && in_bus.ready)) begin
            @(posedge i_clk);
        end
    endtask

    // sender goes quiet until every predicted character has come out
    task automatic wait_drain();
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (pending_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    // lead byte with n leading ones and random payload below them
    function automatic logic [7:0] lead_byte(input int n);
        logic [7:0] ones_part;
        logic [7:0] pay_mask;
        logic [7:0] rnd;
        ones_part = ~(8'hff >> n);
        pay_mask  = 8'hff >> (n + 1);
        rnd       = 8'($urandom_range(255));
        return ones_part | (rnd & pay_mask);
    endfunction

    function automatic int pick_lead_ones();
        int r;
        r = $urandom_range(99);
        if (r < 25) return 0;
        if (r < 35) return 1;
        if (r < 55) return 2;
        if (r < 75) return 3;
        if (r < 90) return 4;
        return $urandom_range(8, 5);
    endfunction

    // mostly well-formed characters, some noise bytes and early buffer ends
    task automatic send_random_stream(input int n_bytes);
        int         sent;
        int         n;
        int         len;
        logic [7:0] b;
        sent = 0;
        while (sent < n_bytes) begin
            if ($urandom_range(99) < 12) begin
                send_byte(8'($urandom_range(255)), $urandom_range(15) == 0);
                sent++;
            end else begin
                n   = pick_lead_ones();
                len = (n == 0) ? 1 : n;
                for (int k = 0; k < len; k++) begin
                    if (k == 0) begin
                        b = lead_byte(n);
                    end else if ($urandom_range(99) < 85) begin
                        b = 8'h80 | 8'($urandom_range(63));
                    end else begin
                        b = 8'($urandom_range(255));
                    end
                    send_byte(b, $urandom_range(39) == 0);
                    sent++;
                end
            end
        end
    endtask

    task automatic test_single_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7f, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'hbf, 1'b1);
        wait_drain();
    endtask

    task automatic test_multibyte();
        send_byte(8'hc3, 1'b0);
        send_byte(8'ha9, 1'b1);   // completes on the last byte of the buffer
        send_byte(8'he2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hac, 1'b0);
        send_byte(8'hf0, 1'b0);
        send_byte(8'h9f, 1'b0);
        send_byte(8'h98, 1'b0);
        send_byte(8'h80, 1'b0);
        wait_drain();
    endtask

    task automatic test_unchecked_continuation();
        // lead and ascii bytes taken as continuations
        send_byte(8'he2, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hff, 1'b0);
        wait_drain();
    endtask

    task automatic test_all_ones_lead();
        send_byte(8'hff, 1'b0);
        for (int k = 0; k < 7; k++) begin
            send_byte(8'hbf, 1'b0);
        end
        wait_drain();
    endtask

    task automatic test_cut_off();
        send_byte(8'he2, 1'b0);
        send_byte(8'h82, 1'b1);
        send_byte(8'hf0, 1'b1);
        send_byte(8'h41, 1'b0);
        wait_drain();
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input int n_bytes);
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        send_random_stream(n_bytes);
        wait_drain();
    endtask

    task automatic test_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_req       = 300;
        send_random_stream(150);
        wait_drain();
    endtask

    task automatic test_pause_between_bursts();
        src_idle_pct   = 0;
        sink_stall_pct = 35;
        for (int burst = 0; burst < 5; burst++) begin
            send_random_stream(20);
            wait_drain();
        end
    endtask

    initial begin
        mismatches     = 0;
        cycle_count    = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_req       = 0;
        hold_left      = 0;
        dec_remaining  = '0;
        dec_accum      = '0;
        dec_length     = '0;
        i_rst_n              = 1'b0;
        in_bus.valid         = 1'b0;
        in_bus.byte_value    = '0;
        in_bus.end_of_buffer = 1'b0;
        out_bus.ready        = 1'b0;
        repeat (RESET_LEN) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_single_bytes();
        test_multibyte();
        test_unchecked_continuation();
        test_all_ones_lead();
        test_cut_off();
        test_random_phase(0, 0, 300);
        test_random_phase(85, 0, 300);
        test_random_phase(0, 85, 300);
        test_random_phase(35, 35, 300);
        test_backpressure();
        test_pause_between_bursts();

        if (mismatches == 0 && pending_chars.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### utf8_stream_decoder.f
rtl/core/u8d_pkg.sv
rtl/core/u8d_in_if.sv
rtl/core/u8d_out_if.sv
rtl/core/u8d_in_reg.sv
rtl/core/u8d_decode.sv
rtl/core/u8d_out_reg.sv
rtl/core/utf8_stream_decoder.sv
verif/tb_utf8_stream_decoder.sv
